[sv/sdaf_pkg.sv]
// ----------------------------------------------------------------------------
// sdaf_pkg
// shared types, constants and helpers of the signed decimal ascii formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sdaf_pkg;

   localparam int          NUM_W       = 18;
   localparam int          DIGITS_DEF  = 5;
   localparam int          CHAR_W      = 8;
   localparam int          DIGIT_W     = 4;
   localparam logic [7:0]  ASCII_ZERO  = 8'h30;
   localparam logic [7:0]  ASCII_MINUS = 8'h2D;

   // control bits that travel with an item through the digit pipeline
   typedef struct packed {
      logic valid;
      logic neg;
      logic started;
   } ctl_type;

   // ten to the power n, elaboration use only
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int k = 0; k < n; k++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   // bits needed to hold magnitudes up to 10**digits - 1, never below NUM_W
   function automatic int mag_width(input int digits);
      int w;
      w = $clog2(pow10(digits));
      return (w > NUM_W) ? w : NUM_W;
   endfunction

endpackage

`default_nettype wire

[sv/sdaf_front.sv]
// ----------------------------------------------------------------------------
// sdaf_front
// entry stage: sign split, magnitude and saturation to the digit range
// ----------------------------------------------------------------------------
`default_nettype none

module sdaf_front #(
   parameter int DIGITS = 5,
   parameter int MAG_W  = 18
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        load,
   input  wire logic [sdaf_pkg::NUM_W-1:0]  number,
   output      sdaf_pkg::ctl_type           ctl_out,
   output      logic [MAG_W-1:0]            mag_out
);
   import sdaf_pkg::*;

   localparam logic [63:0] LIMIT = pow10(DIGITS) - 64'd1;

   logic             neg;
   logic [NUM_W-1:0] mag_raw;
   logic [MAG_W-1:0] mag_ext;
   logic [MAG_W-1:0] mag_in;
   logic             valid_ff;
   logic             neg_ff;
   logic [MAG_W-1:0] mag_ff;

   assign neg     = number[NUM_W-1];
   assign mag_raw = neg ? (~number + 1'b1) : number;
   assign mag_ext = MAG_W'(mag_raw);
   // clamp to the largest value that fits the digit count, sign kept
   assign mag_in  = (mag_ext > MAG_W'(LIMIT)) ? MAG_W'(LIMIT) : mag_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= neg;
         mag_ff <= mag_in;
      end
   end

   assign ctl_out = '{valid: valid_ff, neg: neg_ff, started: 1'b0};
   assign mag_out = mag_ff;

endmodule

`default_nettype wire

[sv/sdaf_digit.sv]
// ----------------------------------------------------------------------------
// sdaf_digit
// one pipeline stage that peels off the decimal digit of weight 10**PLACE_EXP
// ----------------------------------------------------------------------------
`default_nettype none

module sdaf_digit #(
   parameter int DIGITS    = 5,
   parameter int MAG_W     = 18,
   parameter int CNT_W     = 3,
   parameter int SLOT      = 0,
   parameter int PLACE_EXP = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire sdaf_pkg::ctl_type             ctl_in,
   input  wire logic [MAG_W-1:0]              rem_in,
   input  wire logic [DIGITS*4-1:0]           digits_in,
   input  wire logic [CNT_W-1:0]              cnt_in,
   output      sdaf_pkg::ctl_type             ctl_out,
   output      logic [MAG_W-1:0]              rem_out,
   output      logic [DIGITS*4-1:0]           digits_out,
   output      logic [CNT_W-1:0]              cnt_out
);
   import sdaf_pkg::*;

   localparam logic [63:0] PLACE = pow10(PLACE_EXP);

   logic [DIGIT_W-1:0]    dig;
   logic [MAG_W-1:0]      sub;
   logic                  started_in;
   logic [DIGITS*4-1:0]   digits_in_v;
   logic                  valid_ff;
   logic                  neg_ff;
   logic                  started_ff;
   logic [MAG_W-1:0]      rem_ff;
   logic [DIGITS*4-1:0]   digits_ff;
   logic [CNT_W-1:0]      cnt_ff;

   // nine parallel compares against the multiples of the place weight
   always_comb begin
      dig = '0;
      sub = '0;
      for (int j = 1; j < 10; j++) begin
         if (rem_in >= MAG_W'(PLACE * 64'(j))) begin
            dig = DIGIT_W'(j);
            sub = MAG_W'(PLACE * 64'(j));
         end
      end
   end

   assign started_in = ctl_in.started | (dig != '0);

   always_comb begin
      digits_in_v = digits_in;
      digits_in_v[SLOT*DIGIT_W +: DIGIT_W] = dig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff     <= ctl_in.neg;
         started_ff <= started_in;
         rem_ff     <= rem_in - sub;
         digits_ff  <= digits_in_v;
         cnt_ff     <= cnt_in + CNT_W'(started_in);
      end
   end

   assign ctl_out    = '{valid: valid_ff, neg: neg_ff, started: started_ff};
   assign rem_out    = rem_ff;
   assign digits_out = digits_ff;
   assign cnt_out    = cnt_ff;

endmodule

`default_nettype wire

[sv/sdaf_serial.sv]
// ----------------------------------------------------------------------------
// sdaf_serial
// character serializer: sign first, then the significant digits
// ----------------------------------------------------------------------------
`default_nettype none

module sdaf_serial #(
   parameter int DIGITS = 5,
   parameter int CNT_W  = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sdaf_pkg::ctl_type             ctl_in,
   input  wire logic [DIGITS*4-1:0]           digits_in,
   input  wire logic [CNT_W-1:0]              cnt_in,
   output      logic                          take,
   output      logic                          rsp_valid,
   output      logic [sdaf_pkg::CHAR_W-1:0]   rsp_text_char,
   output      logic                          rsp_final_char
);
   import sdaf_pkg::*;

   logic                  neg_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [DIGITS*4-1:0]   digits_ff;
   logic                  neg_in;
   logic [CNT_W-1:0]      rem_in;
   logic                  load;
   logic [DIGIT_W-1:0]    cur_digit;

   // free now, or sending its last character this cycle
   assign take = (rem_ff == '0) || ((rem_ff == CNT_W'(1)) && !neg_ff);
   assign load = take && ctl_in.valid;

   always_comb begin
      neg_in = neg_ff;
      rem_in = rem_ff;
      if (load) begin
         neg_in = ctl_in.neg;
         // zero has no significant digit but still prints one '0'
         rem_in = (cnt_in == '0) ? CNT_W'(1) : cnt_in;
      end else if (neg_ff) begin
         neg_in = 1'b0;
      end else if (rem_ff != '0) begin
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
         rem_ff <= '0;
      end else begin
         neg_ff <= neg_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= digits_in;
      end
   end

   // remaining count selects the digit slot, counted from the least significant end
   always_comb begin
      cur_digit = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (rem_ff == CNT_W'(DIGITS - i)) begin
            cur_digit = digits_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign rsp_valid      = neg_ff || (rem_ff != '0);
   assign rsp_text_char  = neg_ff ? ASCII_MINUS : (ASCII_ZERO | CHAR_W'(cur_digit));
   assign rsp_final_char = !neg_ff && (rem_ff == CNT_W'(1));

endmodule

`default_nettype wire

[sv/signed_decimal_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter
// signed integer to decimal ascii text, one character per output strobe
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Its text comes out
// one character per cycle on rsp_text_char with rsp_valid high: a '-' for
// negatives, then the digits without leading zeros, zero giving a single '0';
// rsp_final_char marks the last character. The receiver cannot stall, so the
// strobe is never held. A number passes the entry register, the digit
// stages and the serializer register before its first character appears.
// The serializer at the pipeline end sets the rate: a number occupies it
// while its characters (1 to DIGITS + 1) go out, it takes the next number
// in the cycle of the last character, and busy is raised only while the
// next finished number waits for it, so short numbers follow each other
// closely. Magnitudes above 10**DIGITS - 1 are clamped to that value with the sign kept.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_ascii_formatter #(
   parameter int DIGITS = sdaf_pkg::DIGITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [sdaf_pkg::NUM_W-1:0]    req_number,
   output      logic                          rsp_valid,
   output      logic [sdaf_pkg::CHAR_W-1:0]   rsp_text_char,
   output      logic                          rsp_final_char
);
   import sdaf_pkg::*;

   localparam int MAG_W = mag_width(DIGITS);
   localparam int CNT_W = $clog2(DIGITS + 1);

   // stage chain: index 0 is the entry stage, index k after k digit stages
   ctl_type               ctl_chain    [DIGITS+1];
   logic [MAG_W-1:0]      rem_chain    [DIGITS+1];
   logic [DIGITS*4-1:0]   digits_chain [DIGITS+1];
   logic [CNT_W-1:0]      cnt_chain    [DIGITS+1];

   logic                  adv;
   logic                  ser_take;

   // the whole pipeline moves together; it holds only while its last item
   // waits for the serializer
   assign adv  = !ctl_chain[DIGITS].valid || ser_take;
   assign busy = !adv;

   sdaf_front #(
      .DIGITS (DIGITS),
      .MAG_W  (MAG_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .load    (start),
      .number  (req_number),
      .ctl_out (ctl_chain[0]),
      .mag_out (rem_chain[0])
   );

   assign digits_chain[0] = '0;
   assign cnt_chain[0]    = '0;

   // one stage per decimal place, most significant first
   for (genvar k = 0; k < DIGITS; k++) begin : g_digit
      sdaf_digit #(
         .DIGITS    (DIGITS),
         .MAG_W     (MAG_W),
         .CNT_W     (CNT_W),
         .SLOT      (k),
         .PLACE_EXP (DIGITS - 1 - k)
      ) u_digit (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .ctl_in     (ctl_chain[k]),
         .rem_in     (rem_chain[k]),
         .digits_in  (digits_chain[k]),
         .cnt_in     (cnt_chain[k]),
         .ctl_out    (ctl_chain[k+1]),
         .rem_out    (rem_chain[k+1]),
         .digits_out (digits_chain[k+1]),
         .cnt_out    (cnt_chain[k+1])
      );
   end

   // remainder after the last place is always zero and is not used further
   sdaf_serial #(
      .DIGITS (DIGITS),
      .CNT_W  (CNT_W)
   ) u_serial (
      .clock          (clock),
      .reset          (reset),
      .ctl_in         (ctl_chain[DIGITS]),
      .digits_in      (digits_chain[DIGITS]),
      .cnt_in         (cnt_chain[DIGITS]),
      .take           (ser_take),
      .rsp_valid      (rsp_valid),
      .rsp_text_char  (rsp_text_char),
      .rsp_final_char (rsp_final_char)
   );

   // a text that is not finished goes on in the very next cycle
   a_text_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_char |=> rsp_valid)
      else $error("character strobe gap inside one number");

   // the sign never closes a text
   a_minus_not_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_text_char == ASCII_MINUS) |-> !rsp_final_char)
      else $error("minus sign marked as last character");

   // after a digit of an unfinished text only digits follow
   a_digit_after_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_char && (rsp_text_char != ASCII_MINUS)
      |=> rsp_text_char != ASCII_MINUS)
      else $error("minus sign after a digit");

   // the last digit stage holds an item and the serializer is sending whenever busy is shown
   a_busy_means_full : assert property (@(posedge clock) disable iff (reset)
      busy |-> ctl_chain[DIGITS].valid && rsp_valid)
      else $error("busy raised with the serializer idle");

   // an item never drains from the pipe while it is held
   a_hold_keeps_last : assert property (@(posedge clock) disable iff (reset)
      busy |=> ctl_chain[DIGITS].valid)
      else $error("stalled item lost from the last digit stage");

endmodule

`default_nettype wire

[sim/sdaf_checker.sv]
// ----------------------------------------------------------------------------
// sdaf_checker
// predicts the decimal text of each accepted number and checks every character
// ----------------------------------------------------------------------------
module sdaf_checker #(
   parameter int DIGITS = sdaf_pkg::DIGITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [sdaf_pkg::NUM_W-1:0]    req_number,
   input  wire logic                          rsp_valid,
   input  wire logic [sdaf_pkg::CHAR_W-1:0]   rsp_text_char,
   input  wire logic                          rsp_final_char,
   output int                                 fail_count,
   output int                                 chars_pending,
   output int                                 numbers_seen,
   output int                                 chars_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import sdaf_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_entry_type;

   text_entry_type expected_text[$];

   // decimal text of one number, appended to the expected characters
   task automatic predict_text(input logic [NUM_W-1:0] raw);
      text_entry_type digits_q[$];
      text_entry_type e;
      logic        neg;
      longint      mag;
      longint      place;
      longint      limit;
      longint      d;
      bit          started;
      neg = raw[NUM_W-1];
      mag = neg ? ((longint'(1) << NUM_W) - longint'(raw)) : longint'(raw);
      place = 1;
      for (int k = 1; k < DIGITS; k++) begin
         place = place * 10;
      end
      limit = place * 10 - 1;
      if (mag > limit) begin
         mag = limit;
      end
      started = 1'b0;
      if (mag == 0) begin
         e.ch = ASCII_ZERO;
         e.last = 1'b1;
         digits_q.push_back(e);
      end else begin
         if (neg) begin
            e.ch = ASCII_MINUS;
            e.last = 1'b0;
            digits_q.push_back(e);
         end
         while (place > 0) begin
            d = mag / place;
            if (d != 0 || started) begin
               e.ch = ASCII_ZERO + CHAR_W'(d);
               e.last = 1'b0;
               digits_q.push_back(e);
               mag = mag - d * place;
               started = 1'b1;
            end
            place = place / 10;
         end
         digits_q[digits_q.size()-1].last = 1'b1;
      end
      foreach (digits_q[i]) begin
         expected_text.push_back(digits_q[i]);
      end
   endtask

   always @(posedge clock) begin
      text_entry_type want;
      if (reset) begin
         fail_count = 0;
         chars_pending = 0;
         numbers_seen = 0;
         chars_seen = 0;
         expected_text.delete();
      end else begin
         if (rsp_valid) begin
            chars_seen = chars_seen + 1;
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected character, expected none, got char %h final %b",
                        $time, rsp_text_char, rsp_final_char);
               fail_count = fail_count + 1;
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_char !== want.ch) begin
                  $display("%0t: text_char mismatch, expected %h, got %h",
                           $time, want.ch, rsp_text_char);
                  fail_count = fail_count + 1;
               end
               if (rsp_final_char !== want.last) begin
                  $display("%0t: final_char mismatch, expected %b, got %b",
                           $time, want.last, rsp_final_char);
                  fail_count = fail_count + 1;
               end
            end
         end
         // predicted after the compare: new text never arrives in the same cycle
         if (start && !busy) begin
            predict_text(req_number);
            numbers_seen = numbers_seen + 1;
         end
         chars_pending = expected_text.size();
      end
   end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the signed decimal ascii formatter
// ----------------------------------------------------------------------------
// Numbers are offered with start at the falling edge and held until taken
// (start high, busy low at a rising edge). A directed set covers zero, the
// single-digit and full-width extremes, powers of ten, saturating values and
// alternating bit patterns; then random numbers follow, mostly in range with
// a share of short magnitudes, raw 18-bit values and edge values. The checker
// beside the block predicts every character and counts mismatches; a watchdog
// ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sdaf_pkg::*;

   localparam int DIGITS        = DIGITS_DEF;
   localparam int RANDOM_ITEMS  = 195;
   localparam int STALL_LIMIT   = 500;
   localparam int QUIET_FROM    = 90;   // random items in this window never idle
   localparam int QUIET_TO      = 150;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [NUM_W-1:0]  req_number;
   logic              rsp_valid;
   logic [CHAR_W-1:0] rsp_text_char;
   logic              rsp_final_char;

   int fail_count;
   int chars_pending;
   int numbers_seen;
   int chars_seen;
   int clamped_count;
   int stall_cycles;

   signed_decimal_ascii_formatter #(.DIGITS(DIGITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_text_char  (rsp_text_char),
      .rsp_final_char (rsp_final_char)
   );

   sdaf_checker #(.DIGITS(DIGITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_text_char  (rsp_text_char),
      .rsp_final_char (rsp_final_char),
      .fail_count     (fail_count),
      .chars_pending  (chars_pending),
      .numbers_seen   (numbers_seen),
      .chars_seen     (chars_seen)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: cycles with neither an item taken nor a character out
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d characters still pending",
                  $time, chars_pending);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // largest magnitude the block can print
   function automatic int max_magnitude();
      int p;
      p = 1;
      for (int k = 0; k < DIGITS; k++) begin
         p = p * 10;
      end
      return p - 1;
   endfunction

   // offer one number, optionally after a random idle gap, and wait until taken
   task automatic send_number(input int value, input bit may_idle);
      int gap;
      int mag;
      if (may_idle && $urandom_range(0, 99) < 12) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_number <= value[NUM_W-1:0];
      // count values whose magnitude will saturate
      mag = (value < 0) ? -value : value;
      if (mag > max_magnitude()) begin
         clamped_count = clamped_count + 1;
      end
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // random number: mostly in range, some short, raw or at a digit boundary
   function automatic int random_number();
      int pick;
      int ndig;
      int p;
      int v;
      logic [NUM_W-1:0] raw;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         v = int'($urandom_range(0, 2 * max_magnitude())) - max_magnitude();
      end else if (pick < 75) begin
         ndig = $urandom_range(1, DIGITS);
         p = 1;
         for (int k = 0; k < ndig; k++) begin
            p = p * 10;
         end
         v = $urandom_range(0, p - 1);
         if ($urandom_range(0, 1)) begin
            v = -v;
         end
      end else if (pick < 90) begin
         raw = NUM_W'($urandom());
         v = int'($signed(raw));
      end else begin
         ndig = $urandom_range(0, DIGITS);
         p = 1;
         for (int k = 0; k < ndig; k++) begin
            p = p * 10;
         end
         // a power of ten or one below it, either sign
         v = p - $urandom_range(0, 1);
         if ($urandom_range(0, 1)) begin
            v = -v;
         end
      end
      return v;
   endfunction

   initial begin
      int directed[$];
      int wait_cycles;
      clamped_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_number = '0;

      // zero, single digits, powers of ten, full width, saturation, bit patterns
      directed = '{0, 1, -1, 9, -9, 10, -10, 100, 1000, -10000, 10000,
                   99999, -99999, 100000, -100000, 131071, -131072,
                   12345, -54321, 90909, -10001, 87381, -87382, 7, -60};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         send_number(directed[i], 1'b1);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_number(random_number(), !(i >= QUIET_FROM && i < QUIET_TO));
      end

      start <= 1'b0;
      // drain: the watchdog covers a block that stops short
      while (chars_pending != 0) begin
         @(posedge clock);
      end
      // then keep watching to catch stray characters
      wait_cycles = 2 * (DIGITS + 4);
      repeat (wait_cycles) @(posedge clock);

      $display("formatted %0d numbers (%0d saturating), %0d characters checked",
               numbers_seen, clamped_count, chars_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
